>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, skipped while reset is high
`define QPH_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, also checked during reset
`define QPH_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/qph_pkg.sv
// shared types, constants and codes of the quadratic probe hash table
package qph_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int CFG_W           = 11;
  localparam int NUM_W           = 16;
  localparam int YEAR_W          = 14;
  localparam int PROF_W          = 32;
  localparam int KEY_W           = YEAR_W + NUM_W + PROF_W;
  localparam int SLOT_W          = 10;
  localparam int PROBE_W         = 11;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = CFG_W'(1024);

  localparam logic REG_TABLE_SIZE = 1'b0;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [1:0] STAT_INSERTED  = 2'd0;
  localparam logic [1:0] STAT_DROPPED   = 2'd1;
  localparam logic [1:0] STAT_FOUND     = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic              opcode;
    logic [YEAR_W-1:0] course_year;
    logic [NUM_W-1:0]  course_number;
    logic [PROF_W-1:0] professor_id;
  } qph_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [PROBE_W-1:0] probe_count;
    logic               collided;
  } qph_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CHECK,
    ST_STEP,
    ST_DONE
  } qph_state_t;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic       home;
    logic       check;
    logic       insert_wr;
    logic       finish;
    logic [1:0] res_status;
    logic       step;
    logic       out_load;
  } qph_cmd_t;

  typedef struct packed {
    logic empty;
    logic match;
    logic bound;
    logic is_search;
    logic clr_last;
    logic div_done;
    logic out_free;
  } qph_status_t;

endpackage

>>> src/quadratic_probe_hash_table_core.sv
// Open-addressing hash table with cumulative quadratic probing. Keys are
// (course_year, course_number, professor_id); the home slot is course_number
// modulo the active size (table_size clamped to 1..TABLE_DEPTH) and step x
// adds x*x. One item is worked at a time, and the result register lets the
// next item enter while a result waits. After reset a clearing pass writes
// every slot empty, during which no item is taken. An item then passes the
// serial remainder unit for the home slot, and each probe is the registered
// read of the slot memory (one write and one read port), the compare and the
// index step.
module quadratic_probe_hash_table_core #(
  parameter int TABLE_DEPTH = qph_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  qph_pkg::qph_in_t            item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output qph_pkg::qph_out_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qph_pkg::PADDR_W-1:0] paddr,
  input  logic [qph_pkg::PDATA_W-1:0] pwdata,
  output logic [qph_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import qph_pkg::*;

  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (CFG_W > SW) ? CFG_W : SW;

  logic [CFG_W-1:0] table_size;
  logic             reg_sel;
  logic             cfg_we;
  logic [CW-1:0]    size_w;
  logic [SW-1:0]    size;
  qph_cmd_t         cmd;
  qph_status_t      st;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_TABLE_SIZE);
  assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? PDATA_W'(table_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RST;
    end else if (cfg_we) begin
      table_size <= pwdata[CFG_W-1:0];
    end
  end

  // clamp into 1..TABLE_DEPTH
  always_comb begin
    size_w = CW'(table_size);
    if (table_size == '0) begin
      size_w = CW'(1);
    end else if (CW'(table_size) > CW'(TABLE_DEPTH)) begin
      size_w = CW'(TABLE_DEPTH);
    end
  end
  assign size = size_w[SW-1:0];

  qph_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .st        (st),
    .cmd       (cmd)
  );

  qph_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .item        (item),
    .size        (size),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

>>> src/qph_div.sv
// bit-serial remainder unit, one dividend bit per cycle
module qph_div #(
  parameter int DIV_W = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [qph_pkg::NUM_W-1:0] dividend,
  input  logic [DIV_W-1:0]         divisor,
  output logic                     done,
  output logic [DIV_W-1:0]         rem
);
  import qph_pkg::*;

  localparam int CW = $clog2(NUM_W);

  logic             run;
  logic [CW-1:0]    cnt;
  logic [NUM_W-1:0] sh;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   dvs;
  logic [DIV_W:0]   red;
  logic             last;

  assign last  = (cnt == CW'(NUM_W - 1));
  assign trial = {rem, sh[NUM_W-1]};
  assign dvs   = {1'b0, divisor};
  assign red   = (trial >= dvs) ? (trial - dvs) : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= run && last;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CW'(1);
        if (last) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      rem <= '0;
    end else if (run) begin
      sh  <= {sh[NUM_W-2:0], 1'b0};
      rem <= red[DIV_W-1:0];
    end
  end

endmodule

>>> src/qph_mem.sv
// slot memory, one write port and one registered read port
module qph_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 63
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/qph_dp.sv
// datapath: item register, probe arithmetic, slot memory and result register
module qph_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  qph_pkg::qph_cmd_t                  cmd,
  output qph_pkg::qph_status_t               st,
  input  qph_pkg::qph_in_t                   item,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   size,
  output logic                               result_valid,
  input  logic                               result_ready,
  output qph_pkg::qph_out_t                  result
);
  import qph_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = IW + 1;
  localparam int MW = KEY_W + 1;
  localparam int XW = ($clog2(TABLE_DEPTH + 2) > PROBE_W) ? $clog2(TABLE_DEPTH + 2) : PROBE_W;
  localparam int CW = (XW > SW) ? XW : SW;
  localparam int PW = (IW > SLOT_W) ? IW : SLOT_W;

  qph_in_t        item_q;
  logic [IW-1:0]  idx;
  logic [XW-1:0]  x;
  logic [IW-1:0]  sqn;
  logic [IW-1:0]  incn;
  logic           coll;
  logic [1:0]     res_status;
  logic [IW-1:0]  sweep;

  logic [SW-1:0]  div_rem;
  logic           div_done;

  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  logic [MW-1:0]  mem_wdata;
  logic [MW-1:0]  rdata;
  logic [KEY_W-1:0] key;

  logic [AW-1:0]  size_a;
  logic [AW-1:0]  idx_sum;
  logic [AW-1:0]  idx_mod;
  logic [AW-1:0]  sq_sum;
  logic [AW-1:0]  sq_mod;
  logic [AW-1:0]  inc_sum;
  logic [AW-1:0]  inc_m1;
  logic [AW-1:0]  inc_mod;
  logic [IW-1:0]  sqn0;
  logic [IW-1:0]  incn0;
  logic [PW-1:0]  slot_wide;
  logic           hit;

  qph_div #(
    .DIV_W(SW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.load),
    .dividend(item.course_number),
    .divisor (size),
    .done    (div_done),
    .rem     (div_rem)
  );

  assign key       = {item_q.professor_id, item_q.course_number, item_q.course_year};
  assign mem_we    = cmd.clear || cmd.insert_wr;
  assign mem_waddr = cmd.clear ? sweep : idx;
  assign mem_wdata = cmd.clear ? '0 : {1'b1, key};

  qph_mem #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(MW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(idx),
    .rdata(rdata)
  );

  // modular step arithmetic, idx, sqn and incn already below size
  assign size_a  = AW'(size);
  assign idx_sum = {1'b0, idx} + {1'b0, sqn};
  assign idx_mod = (idx_sum >= size_a) ? (idx_sum - size_a) : idx_sum;
  assign sq_sum  = {1'b0, sqn} + {1'b0, incn};
  assign sq_mod  = (sq_sum >= size_a) ? (sq_sum - size_a) : sq_sum;
  assign inc_sum = {1'b0, incn} + AW'(2);
  assign inc_m1  = (inc_sum >= size_a) ? (inc_sum - size_a) : inc_sum;
  assign inc_mod = (inc_m1 >= size_a) ? (inc_m1 - size_a) : inc_m1;

  // 1 and 3 reduced by the active size
  always_comb begin
    if (size == SW'(1)) begin
      sqn0  = '0;
      incn0 = '0;
    end else if (size == SW'(2)) begin
      sqn0  = IW'(1);
      incn0 = IW'(1);
    end else if (size == SW'(3)) begin
      sqn0  = IW'(1);
      incn0 = '0;
    end else begin
      sqn0  = IW'(1);
      incn0 = IW'(3);
    end
  end

  assign st.empty     = !rdata[MW-1];
  assign st.match     = rdata[MW-1] && (rdata[KEY_W-1:0] == key);
  assign st.bound     = (CW'(x) > CW'(size));
  assign st.is_search = (item_q.opcode == OP_SEARCH);
  assign st.clr_last  = (sweep == IW'(TABLE_DEPTH - 1));
  assign st.div_done  = div_done;
  assign st.out_free  = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.clear) begin
      sweep <= sweep + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
      x      <= '0;
      sqn    <= sqn0;
      incn   <= incn0;
      coll   <= 1'b0;
    end
    if (cmd.home) begin
      idx <= IW'(div_rem);
    end
    if (cmd.step) begin
      idx  <= idx_mod[IW-1:0];
      x    <= x + XW'(1);
      sqn  <= sq_mod[IW-1:0];
      incn <= inc_mod[IW-1:0];
    end
    if (cmd.check && (x == '0) && rdata[MW-1] && (item_q.opcode == OP_INSERT)) begin
      coll <= 1'b1;
    end
    if (cmd.finish) begin
      res_status <= cmd.res_status;
    end
  end

  assign hit       = (res_status == STAT_INSERTED) || (res_status == STAT_FOUND);
  assign slot_wide = hit ? PW'(idx) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.status      <= res_status;
      result.slot        <= slot_wide[SLOT_W-1:0];
      result.probe_count <= x[PROBE_W-1:0];
      result.collided    <= coll;
    end
  end

endmodule

>>> src/qph_ctrl.sv
// controller: clearing pass, home slot, probe loop and result hand-off
module qph_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  qph_pkg::qph_status_t st,
  output qph_pkg::qph_cmd_t    cmd
);
  import qph_pkg::*;

  qph_state_t state;
  qph_state_t state_next;
  logic       decided;
  logic [1:0] code;

  // outcome of the slot just read
  always_comb begin
    decided = 1'b0;
    code    = STAT_NOT_FOUND;
    if (!st.is_search) begin
      if (st.empty) begin
        decided = 1'b1;
        code    = STAT_INSERTED;
      end else if (st.bound) begin
        decided = 1'b1;
        code    = STAT_DROPPED;
      end
    end else begin
      if (st.empty) begin
        decided = 1'b1;
        code    = STAT_NOT_FOUND;
      end else if (st.match) begin
        decided = 1'b1;
        code    = STAT_FOUND;
      end else if (st.bound) begin
        decided = 1'b1;
        code    = STAT_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (st.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (st.div_done) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = decided ? ST_DONE : ST_STEP;
      end
      ST_STEP: begin
        state_next = ST_READ;
      end
      ST_DONE: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      ST_DIV: begin
        cmd.home = st.div_done;
      end
      ST_CHECK: begin
        cmd.check      = 1'b1;
        cmd.finish     = decided;
        cmd.res_status = code;
        cmd.insert_wr  = decided && (code == STAT_INSERTED);
      end
      ST_STEP: begin
        cmd.step = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> src/qph_checker.sv
// port-level checks of the hash table core, bound to the top level
`include "assert_macros.svh"

module qph_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input qph_pkg::qph_out_t result
);
  import qph_pkg::*;

  logic item_beat;
  logic res_stall;
  logic res_search;
  logic res_miss;

  assign item_beat  = item_valid && item_ready;
  assign res_stall  = result_valid && !result_ready;
  assign res_search = result_valid &&
                      (result.status == STAT_FOUND || result.status == STAT_NOT_FOUND);
  assign res_miss   = result_valid &&
                      (result.status == STAT_DROPPED || result.status == STAT_NOT_FOUND);

  // clearing pass follows reset
  `QPH_ASSERT_ALWAYS(a_clear_after_rst, clk, rst |=> !item_ready, "item taken during clear")

  // one item in flight
  `QPH_ASSERT(a_one_item, clk, rst, item_beat |=> !item_ready, "second beat taken")

  `QPH_ASSERT(a_res_hold, clk, rst, res_stall |=> result_valid && $stable(result), "result moved")

  `QPH_ASSERT(a_search_no_coll, clk, rst, res_search |-> !result.collided, "search collision")

  `QPH_ASSERT(a_miss_slot_zero, clk, rst, res_miss |-> (result.slot == '0), "slot set on miss")

endmodule

bind quadratic_probe_hash_table_core qph_checker u_qph_checker (.*);

>>> sim/tb.sv
// testbench for quadratic_probe_hash_table_core: directed and random insert/search beats
`timescale 1ns / 100ps

module tb;
  import qph_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam logic [PADDR_W-1:0] ADDR_TABLE_SIZE = PADDR_W'(4 * REG_TABLE_SIZE);
  localparam logic [PADDR_W-1:0] ADDR_UNUSED = PADDR_W'(4 * (REG_TABLE_SIZE + 1));

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  qph_in_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  qph_out_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  quadratic_probe_hash_table_core dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  qph_in_t items_to_send[$];
  qph_in_t inserted_keys[$];
  qph_out_t predicted_results[$];
  qph_out_t oldest_result;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;

  // per-phase size and idling
  int phase_size [16] = '{1, 5, 16, 2, 64, 1025, 37, 8, 128, 0, 2047, 3, 200, 11, 1000, 1024};
  int send_pct [4] = '{0, 49, 0, 36};
  int recv_pct [4] = '{0, 0, 49, 36};

  // shadow copy of the slot memory and size register
  logic slot_used [DEPTH];
  logic [KEY_W-1:0] slot_rec [DEPTH];
  logic [CFG_W-1:0] size_reg = TABLE_SIZE_RST;

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_rec[i] = '0;
    end
  end

  function automatic qph_out_t probe_table(qph_in_t it);
    logic [KEY_W-1:0] k;
    int unsigned sz, idx, x;
    bit done;
    qph_out_t r;
    k = {it.professor_id, it.course_number, it.course_year};
    sz = (size_reg == 0) ? 1 : ((size_reg > DEPTH) ? DEPTH : size_reg);
    idx = it.course_number % sz;
    x = 0;
    r = '0;
    if (it.opcode == OP_INSERT) begin
      r.collided = slot_used[idx];
      while (slot_used[idx] && x <= sz) begin
        x++;
        idx = (idx + x * x) % sz;
      end
      if (!slot_used[idx]) begin
        slot_used[idx] = 1'b1;
        slot_rec[idx] = k;
        r.status = STAT_INSERTED;
        r.slot = idx[SLOT_W-1:0];
      end else begin
        r.status = STAT_DROPPED;
      end
    end else begin
      r.status = STAT_NOT_FOUND;
      done = 1'b0;
      while (!done) begin
        if (!slot_used[idx]) begin
          done = 1'b1;
        end else if (slot_rec[idx] == k) begin
          r.status = STAT_FOUND;
          r.slot = idx[SLOT_W-1:0];
          done = 1'b1;
        end else if (x > sz) begin
          done = 1'b1;
        end else begin
          x++;
          idx = (idx + x * x) % sz;
        end
      end
    end
    r.probe_count = x[PROBE_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item <= items_to_send.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: check result beats, predict on accepted item beats
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (predicted_results.size() == 0) begin
          $error("result beat with no prediction waiting");
          mismatches++;
        end else begin
          oldest_result = predicted_results.pop_front();
          check_field("status", oldest_result.status, result.status);
          check_field("slot", oldest_result.slot, result.slot);
          check_field("probe_count", oldest_result.probe_count, result.probe_count);
          check_field("collided", oldest_result.collided, result.collided);
        end
      end
      if (item_valid && item_ready) begin
        predicted_results.insert(predicted_results.size(), probe_table(item));
      end
    end
  end

  function automatic qph_in_t rec(logic op, int year, int num, logic [31:0] prof);
    qph_in_t it;
    it.opcode = op;
    it.course_year = YEAR_W'(year);
    it.course_number = NUM_W'(num);
    it.professor_id = prof;
    return it;
  endfunction

  task automatic push_item(qph_in_t it);
    items_to_send.insert(items_to_send.size(), it);
    if (it.opcode == OP_INSERT) inserted_keys.insert(inserted_keys.size(), it);
  endtask

  task automatic wait_drained();
    while (items_to_send.size() != 0 || item_valid || predicted_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic apb_xfer(logic wr, logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data,
                          output logic [PDATA_W-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // write a register, then read back table_size
  task automatic cfg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    logic [PDATA_W-1:0] rd;
    apb_xfer(1'b1, addr, data, rd);
    if (addr == ADDR_TABLE_SIZE) size_reg = data[CFG_W-1:0];
    apb_xfer(1'b0, ADDR_TABLE_SIZE, '0, rd);
    check_field("table_size readback", PDATA_W'(size_reg), rd);
    @(negedge clk);
  endtask

  initial begin
    int num_pool [6];
    int pick;
    qph_in_t it;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // extremes at reset size
    push_item(rec(OP_INSERT, 0, 0, 32'h0));
    push_item(rec(OP_INSERT, 9999, 65535, 32'hFFFF_FFFF));
    push_item(rec(OP_SEARCH, 0, 0, 32'h0));
    push_item(rec(OP_SEARCH, 9999, 65535, 32'hFFFF_FFFF));
    push_item(rec(OP_SEARCH, 1, 0, 32'h0));
    push_item(rec(OP_INSERT, 0, 0, 32'h0));
    push_item(rec(OP_SEARCH, 0, 0, 32'h0));
    wait_drained();

    // size zero behaves as one, probe bound reached on a miss
    cfg_write(ADDR_TABLE_SIZE, 32'hFFFF_F800);
    push_item(rec(OP_INSERT, 5, 3, 32'd77));
    push_item(rec(OP_SEARCH, 0, 0, 32'h0));
    push_item(rec(OP_SEARCH, 5, 3, 32'd77));
    push_item(rec(OP_SEARCH, 9999, 65535, 32'hFFFF_FFFF));
    wait_drained();

    // oversize clamps to full depth; unused register index ignored
    cfg_write(ADDR_TABLE_SIZE, 32'hA5A5_AFFF);
    cfg_write(ADDR_UNUSED, 32'h0000_0003);
    push_item(rec(OP_SEARCH, 9999, 65535, 32'hFFFF_FFFF));
    push_item(rec(OP_INSERT, 42, 1023, 32'h1234_5678));
    wait_drained();

    // shrink with entries present, fill and overflow
    cfg_write(ADDR_TABLE_SIZE, 32'd3);
    push_item(rec(OP_INSERT, 1, 1, 32'd1));
    push_item(rec(OP_INSERT, 2, 2, 32'd2));
    push_item(rec(OP_INSERT, 7, 7, 32'd7));
    push_item(rec(OP_SEARCH, 2, 2, 32'd2));
    push_item(rec(OP_SEARCH, 8, 8, 32'd8));
    wait_drained();

    // grow back, high entries reachable again
    cfg_write(ADDR_TABLE_SIZE, 32'd1024);
    push_item(rec(OP_SEARCH, 42, 1023, 32'h1234_5678));
    push_item(rec(OP_SEARCH, 9999, 65535, 32'hFFFF_FFFF));
    wait_drained();

    for (int p = 0; p < 16; p++) begin
      cfg_write(ADDR_TABLE_SIZE, {PDATA_W'($urandom)} & ~PDATA_W'(11'h7FF) |
                                 PDATA_W'(phase_size[p]));
      send_idle_pct = send_pct[p % 4];
      recv_idle_pct = recv_pct[p % 4];
      foreach (num_pool[j]) num_pool[j] = $urandom_range(65535);
      for (int n = 0; n < 110; n++) begin
        pick = $urandom_range(99);
        it.opcode = OP_INSERT;
        it.course_year = YEAR_W'($urandom_range(9999));
        it.course_number = NUM_W'(($urandom_range(99) < 70) ? num_pool[$urandom_range(5)]
                                                            : $urandom_range(65535));
        it.professor_id = $urandom;
        if (pick >= 40 && inserted_keys.size() != 0) begin
          it = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
          it.opcode = (pick < 50) ? OP_INSERT : OP_SEARCH;
          // near miss on one key field
          if (pick >= 80 && pick < 90) begin
            case ($urandom_range(2))
              0: it.course_year = YEAR_W'((it.course_year + 1 + $urandom_range(9998)) % 10000);
              1: it.course_number = it.course_number ^ (16'd1 << $urandom_range(15));
              default: it.professor_id = it.professor_id ^ (32'd1 << $urandom_range(31));
            endcase
          end
        end
        if (pick >= 90) begin
          it.opcode = OP_SEARCH;
          it.course_year = YEAR_W'($urandom_range(9999));
          it.course_number = NUM_W'($urandom_range(65535));
          it.professor_id = $urandom;
        end
        push_item(it);
      end
      wait_drained();
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (200) @(posedge clk);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("quadratic_probe_hash_table_core verification clean");
    end else begin
      $display("quadratic_probe_hash_table_core verification failed");
    end
    $finish;
  end

  initial begin
    #500_000_000;
    $display("quadratic_probe_hash_table_core verification failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/qph_pkg.sv
src/qph_div.sv
src/qph_mem.sv
src/qph_dp.sv
src/qph_ctrl.sv
src/quadratic_probe_hash_table_core.sv
src/qph_checker.sv
sim/tb.sv
